@@ hw/rtl/tbf_pkg.sv @@
package tbf_pkg;

    // Default width of the file position counter.
    localparam int OFFSET_BITS_DEF = 32;

    // Result roles
    localparam logic [2:0] ROLE_HEADER  = 3'd0;
    localparam logic [2:0] ROLE_ID      = 3'd1;
    localparam logic [2:0] ROLE_BODY    = 3'd2;
    localparam logic [2:0] ROLE_IGNORED = 3'd3;
    localparam logic [2:0] ROLE_END_OK  = 3'd4;
    localparam logic [2:0] ROLE_END_ERR = 3'd5;

    // Error codes
    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_NOT_TZX    = 3'd1;
    localparam logic [2:0] ERR_BAD_VER    = 3'd2;
    localparam logic [2:0] ERR_UNKNOWN    = 3'd3;
    localparam logic [2:0] ERR_HDR_TRUNC  = 3'd4;
    localparam logic [2:0] ERR_DATA_TRUNC = 3'd5;

    // Block layout kinds
    localparam logic [1:0] KIND_UNKNOWN = 2'd0;
    localparam logic [1:0] KIND_FIXED   = 2'd1;
    localparam logic [1:0] KIND_SIZED   = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [4:0] prefix;  // fixed body length, or length of the header prefix
        logic [4:0] at;      // offset of the count within the prefix
        logic [2:0] size;    // count width in bytes
        logic [1:0] scale;   // count multiplier
    } layout_t;

    typedef struct packed {
        logic [2:0]  byte_role;
        logic [7:0]  block_code;
        logic [31:0] block_start;
        logic [32:0] body_length;
        logic        block_done;
        logic [2:0]  error_code;
    } result_t;

    function automatic layout_t lay(input logic [1:0] kind, input logic [4:0] prefix,
                                    input logic [4:0] at, input logic [2:0] size,
                                    input logic [1:0] scale);
        layout_t l;
        l.kind   = kind;
        l.prefix = prefix;
        l.at     = at;
        l.size   = size;
        l.scale  = scale;
        return l;
    endfunction

    function automatic layout_t describe(input logic [7:0] code);
        layout_t l;
        case (code)
            8'h10:                      l = lay(KIND_SIZED, 5'd4, 5'd2, 3'd2, 2'd1);
            8'h11:                      l = lay(KIND_SIZED, 5'd18, 5'd15, 3'd3, 2'd1);
            8'h12:                      l = lay(KIND_FIXED, 5'd4, 5'd0, 3'd0, 2'd1);
            8'h13:                      l = lay(KIND_SIZED, 5'd1, 5'd0, 3'd1, 2'd2);
            8'h14:                      l = lay(KIND_SIZED, 5'd10, 5'd7, 3'd3, 2'd1);
            8'h15:                      l = lay(KIND_SIZED, 5'd8, 5'd5, 3'd3, 2'd1);
            8'h16, 8'h17, 8'h18, 8'h19: l = lay(KIND_SIZED, 5'd4, 5'd0, 3'd4, 2'd1);
            8'h20:                      l = lay(KIND_FIXED, 5'd2, 5'd0, 3'd0, 2'd1);
            8'h21:                      l = lay(KIND_SIZED, 5'd1, 5'd0, 3'd1, 2'd1);
            8'h22:                      l = lay(KIND_FIXED, 5'd0, 5'd0, 3'd0, 2'd1);
            8'h23, 8'h24:               l = lay(KIND_FIXED, 5'd2, 5'd0, 3'd0, 2'd1);
            8'h25, 8'h27:               l = lay(KIND_FIXED, 5'd0, 5'd0, 3'd0, 2'd1);
            8'h26:                      l = lay(KIND_SIZED, 5'd2, 5'd0, 3'd2, 2'd2);
            8'h28:                      l = lay(KIND_SIZED, 5'd2, 5'd0, 3'd2, 2'd1);
            8'h2a, 8'h2b:               l = lay(KIND_SIZED, 5'd4, 5'd0, 3'd4, 2'd1);
            8'h30:                      l = lay(KIND_SIZED, 5'd1, 5'd0, 3'd1, 2'd1);
            8'h31:                      l = lay(KIND_SIZED, 5'd2, 5'd1, 3'd1, 2'd1);
            8'h32:                      l = lay(KIND_SIZED, 5'd2, 5'd0, 3'd2, 2'd1);
            8'h33:                      l = lay(KIND_SIZED, 5'd1, 5'd0, 3'd1, 2'd3);
            8'h34:                      l = lay(KIND_FIXED, 5'd8, 5'd0, 3'd0, 2'd1);
            8'h35:                      l = lay(KIND_SIZED, 5'd20, 5'd16, 3'd4, 2'd1);
            8'h40:                      l = lay(KIND_SIZED, 5'd4, 5'd1, 3'd3, 2'd1);
            8'h5a:                      l = lay(KIND_FIXED, 5'd9, 5'd0, 3'd0, 2'd1);
            default:                    l = lay(KIND_UNKNOWN, 5'd0, 5'd0, 3'd0, 2'd1);
        endcase
        return l;
    endfunction

    // "ZXTape!" then 0x1a
    function automatic logic [7:0] sig_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h5a;
            3'd1:    b = 8'h58;
            3'd2:    b = 8'h54;
            3'd3:    b = 8'h61;
            3'd4:    b = 8'h70;
            3'd5:    b = 8'h65;
            3'd6:    b = 8'h21;
            default: b = 8'h1a;
        endcase
        return b;
    endfunction

endpackage

@@ hw/rtl/tzx_block_framer.sv @@
// TZX block framer.
// Input channel (s_*): one beat per image byte on s_data_byte; a beat with
//   s_end_of_stream high carries no byte and closes the image.
// Result channel (m_*): exactly one beat per input beat, in order: the byte's
//   role, the current block's id, start offset and body length, a
//   block-complete flag and the sticky error code.
// Path: an input beat is held in the input register, then passes through the
//   framing logic into the result register, which drives m_valid; a stall
//   can hold it in the input register while the result register is full.
// Throughput: one beat per cycle while m_ready stays high; the only loop is
//   the framing state update, which is combinational between its registers.
// Stall: when m_ready is low the result register holds; the input register
//   still takes one more beat, then s_ready falls until the result drains.
//   Nothing is dropped or repeated.
// Reset (aresetn low, synchronous): both registers empty, framer back in the
//   signature phase with position and errors cleared. An end beat does the
//   same to the framing state, ready for the next image.
// OFFSET_BITS sets the width of the file position counter; m_block_start
//   shows its low 32 bits.
module tzx_block_framer
    import tbf_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_end_of_stream,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_byte_role,
    output logic [7:0]  m_block_code,
    output logic [31:0] m_block_start,
    output logic [32:0] m_body_length,
    output logic        m_block_done,
    output logic [2:0]  m_error_code
);

    logic       in_valid;
    logic [7:0] in_data_byte;
    logic       in_end_of_stream;
    logic       can_load;
    logic       advance;
    result_t    res;

    // a held beat moves on when the result register has room
    assign advance = in_valid && can_load;

    tbf_in_reg u_in (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .s_end_of_stream  (s_end_of_stream),
        .advance          (advance),
        .in_valid         (in_valid),
        .in_data_byte     (in_data_byte),
        .in_end_of_stream (in_end_of_stream)
    );

    tbf_parser #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_parser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .take          (advance),
        .data_byte     (in_data_byte),
        .end_of_stream (in_end_of_stream),
        .res           (res)
    );

    tbf_out_reg u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (advance),
        .res           (res),
        .can_load      (can_load),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_byte_role   (m_byte_role),
        .m_block_code  (m_block_code),
        .m_block_start (m_block_start),
        .m_body_length (m_body_length),
        .m_block_done  (m_block_done),
        .m_error_code  (m_error_code)
    );

endmodule

@@ hw/rtl/tbf_in_reg.sv @@
module tbf_in_reg
    import tbf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_end_of_stream,
    input  logic       advance,
    output logic       in_valid,
    output logic [7:0] in_data_byte,
    output logic       in_end_of_stream
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;
    logic       eos_reg;
    logic       load;

    assign s_ready = !valid_reg || advance;
    assign load    = s_valid && s_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= s_data_byte;
            eos_reg  <= s_end_of_stream;
        end
    end

    assign in_valid         = valid_reg;
    assign in_data_byte     = data_reg;
    assign in_end_of_stream = eos_reg;

endmodule

@@ hw/rtl/tbf_parser.sv @@
module tbf_parser
    import tbf_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       take,
    input  logic [7:0] data_byte,
    input  logic       end_of_stream,
    output result_t    res
);

    localparam logic [2:0] PH_SIG    = 3'd0;
    localparam logic [2:0] PH_ID     = 3'd1;
    localparam logic [2:0] PH_PREFIX = 3'd2;
    localparam logic [2:0] PH_BODY   = 3'd3;
    localparam logic [2:0] PH_ERR    = 3'd4;

    logic [2:0]             phase_reg,   phase_next;
    logic [32:0]            index_reg,   index_next;
    logic [7:0]             code_reg,    code_next;
    logic [31:0]            count_reg,   count_next;
    logic [32:0]            length_reg,  length_next;
    logic [OFFSET_BITS-1:0] pos_reg,     pos_next;
    logic [OFFSET_BITS-1:0] origin_reg,  origin_next;
    logic [2:0]             sticky_reg,  sticky_next;

    layout_t                   lay_new;
    layout_t                   lay_cur;
    logic [32:0]               index_inc;
    logic [4:0]                pidx;
    logic [4:0]                diff;
    logic [32:0]               scaled;
    logic [2:0]                end_err;
    logic [OFFSET_BITS+31:0]   origin_ext;
    logic [OFFSET_BITS+31:0]   pos_ext;

    assign lay_new    = describe(data_byte);
    assign lay_cur    = describe(code_reg);
    assign index_inc  = index_reg + 33'd1;
    assign pidx       = index_reg[4:0];
    assign diff       = pidx - lay_cur.at;
    assign origin_ext = {32'd0, origin_reg};
    assign pos_ext    = {32'd0, pos_reg};

    always_comb begin
        phase_next  = phase_reg;
        index_next  = index_reg;
        code_next   = code_reg;
        count_next  = count_reg;
        length_next = length_reg;
        pos_next    = pos_reg + {{(OFFSET_BITS-1){1'b0}}, 1'b1};
        origin_next = origin_reg;
        sticky_next = sticky_reg;
        scaled      = '0;
        end_err     = ERR_NONE;
        res         = '0;

        if (end_of_stream) begin
            if (sticky_reg != ERR_NONE) begin
                end_err = sticky_reg;
            end else if (phase_reg == PH_SIG) begin
                end_err = ERR_NOT_TZX;
            end else if (phase_reg == PH_PREFIX) begin
                end_err = ERR_HDR_TRUNC;
            end else if (phase_reg == PH_BODY) begin
                end_err = ERR_DATA_TRUNC;
            end
            res.byte_role  = (end_err != ERR_NONE) ? ROLE_END_ERR : ROLE_END_OK;
            res.error_code = end_err;
            // back to the reset state for the next image
            phase_next  = PH_SIG;
            index_next  = '0;
            code_next   = '0;
            count_next  = '0;
            length_next = '0;
            pos_next    = '0;
            origin_next = '0;
            sticky_next = ERR_NONE;
        end else begin
            case (phase_reg)
                PH_SIG: begin
                    index_next = index_inc;
                    if (index_reg[3:0] < 4'd8) begin
                        if (data_byte != sig_byte(index_reg[2:0])) begin
                            sticky_next = ERR_NOT_TZX;
                            phase_next  = PH_ERR;
                        end
                    end else if (index_reg[3:0] == 4'd8) begin
                        count_next = {24'd0, data_byte};
                    end else if (count_reg > 32'd1) begin
                        sticky_next = ERR_BAD_VER;
                        phase_next  = PH_ERR;
                    end else begin
                        phase_next = PH_ID;
                        index_next = '0;
                        count_next = '0;
                    end
                    res.byte_role  = ROLE_HEADER;
                    res.error_code = sticky_next;
                end
                PH_ID: begin
                    code_next   = data_byte;
                    origin_next = pos_reg;
                    index_next  = '0;
                    count_next  = '0;
                    length_next = '0;
                    case (lay_new.kind)
                        KIND_FIXED: begin
                            length_next = {28'd0, lay_new.prefix};
                            if (lay_new.prefix == 5'd0) begin
                                res.block_done = 1'b1;
                            end else begin
                                phase_next = PH_BODY;
                            end
                        end
                        KIND_SIZED: begin
                            phase_next = PH_PREFIX;
                        end
                        default: begin
                            sticky_next = ERR_UNKNOWN;
                            phase_next  = PH_ERR;
                        end
                    endcase
                    res.byte_role   = ROLE_ID;
                    res.block_code  = data_byte;
                    res.block_start = pos_ext[31:0];
                    res.body_length = length_next;
                    res.error_code  = sticky_next;
                end
                PH_PREFIX: begin
                    // gather the little-endian count as it passes
                    if (pidx >= lay_cur.at && diff < {2'd0, lay_cur.size}) begin
                        count_next = count_reg | ({24'd0, data_byte} << {diff[1:0], 3'b000});
                    end
                    index_next = index_inc;
                    if (index_inc >= {28'd0, lay_cur.prefix}) begin
                        case (lay_cur.scale)
                            2'd2:    scaled = {count_next, 1'b0};
                            2'd3:    scaled = {1'b0, count_next} + {count_next, 1'b0};
                            default: scaled = {1'b0, count_next};
                        endcase
                        length_next = scaled + {28'd0, lay_cur.prefix};
                        if (length_next == index_inc) begin
                            res.block_done = 1'b1;
                            phase_next     = PH_ID;
                        end else begin
                            phase_next = PH_BODY;
                        end
                    end
                    res.byte_role   = ROLE_BODY;
                    res.block_code  = code_reg;
                    res.block_start = origin_ext[31:0];
                    res.body_length = length_next;
                end
                PH_BODY: begin
                    index_next = index_inc;
                    if (index_inc >= length_reg) begin
                        res.block_done = 1'b1;
                        phase_next     = PH_ID;
                    end
                    res.byte_role   = ROLE_BODY;
                    res.block_code  = code_reg;
                    res.block_start = origin_ext[31:0];
                    res.body_length = length_reg;
                end
                default: begin
                    res.byte_role  = ROLE_IGNORED;
                    res.error_code = sticky_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_SIG;
            index_reg  <= '0;
            code_reg   <= '0;
            count_reg  <= '0;
            length_reg <= '0;
            pos_reg    <= '0;
            origin_reg <= '0;
            sticky_reg <= ERR_NONE;
        end else if (take) begin
            phase_reg  <= phase_next;
            index_reg  <= index_next;
            code_reg   <= code_next;
            count_reg  <= count_next;
            length_reg <= length_next;
            pos_reg    <= pos_next;
            origin_reg <= origin_next;
            sticky_reg <= sticky_next;
        end
    end

endmodule

@@ hw/rtl/tbf_out_reg.sv @@
module tbf_out_reg
    import tbf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load,
    input  result_t     res,
    output logic        can_load,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_byte_role,
    output logic [7:0]  m_block_code,
    output logic [31:0] m_block_start,
    output logic [32:0] m_body_length,
    output logic        m_block_done,
    output logic [2:0]  m_error_code
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign can_load = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

    assign m_valid       = valid_reg;
    assign m_byte_role   = res_reg.byte_role;
    assign m_block_code  = res_reg.block_code;
    assign m_block_start = res_reg.block_start;
    assign m_body_length = res_reg.body_length;
    assign m_block_done  = res_reg.block_done;
    assign m_error_code  = res_reg.error_code;

endmodule
